[hdl/sorted_table_insert_search_unit_defines.svh]
// ----------------------------------------------------------------------------
// sorted_table_insert_search_unit_defines.svh
// Assertion macros shared by the sorted table insert/search unit.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_INSERT_SEARCH_UNIT_DEFINES_SVH
`define SORTED_TABLE_INSERT_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define STSI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define STSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/stsi_pkg.sv]
// ----------------------------------------------------------------------------
// stsi_pkg
// Shared types, field widths and codes of the sorted table insert/search unit.
// ----------------------------------------------------------------------------
package stsi_pkg;

  localparam int KEY_W   = 32;
  localparam int CMD_W   = 2;
  localparam int INDEX_W = 4;
  localparam int COUNT_W = 5;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [CMD_W-1:0]        cmd_t;

  // Command codes
  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_BIN    = 2'd1;
  localparam cmd_t CMD_SEQ    = 2'd2;

  // Which table address the datapath reads for the next step
  typedef enum logic [1:0] {
    RD_BELOW,   // one below the insert cursor
    RD_AT,      // the scan cursor itself
    RD_MID      // binary search midpoint
  } rd_mode_t;

  // Result kind chosen by the controller
  typedef enum logic [1:0] {
    RES_NONE,
    RES_FULL,
    RES_SEQ_HIT,
    RES_BIN_HIT
  } res_code_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic      load;
    logic      load_ins;
    logic      ins_shift;
    logic      ins_place;
    logic      seq_step;
    logic      bin_step;
    logic      res_load;
    rd_mode_t  rd_mode;
    res_code_t res_code;
  } stsi_ctl_t;

  // Datapath -> controller status
  typedef struct packed {
    logic full;
    logic empty;
    logic i_one;
    logic key_lt;
    logic key_eq;
    logic seq_last;
    logic bin_done;
    logic slot_free;
  } stsi_sts_t;

endpackage

[hdl/stsi_if.sv]
// ----------------------------------------------------------------------------
// stsi_if
// Valid/ready channels: command items in, result items out.
// ----------------------------------------------------------------------------
interface stsi_in_if;
  logic              valid;
  logic              ready;
  stsi_pkg::cmd_t    cmd;
  stsi_pkg::key_t    key;

  modport source (output valid, cmd, key, input ready);
  modport sink   (input valid, cmd, key, output ready);
endinterface

interface stsi_out_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [stsi_pkg::INDEX_W-1:0]   index;
  logic                           status;
  logic [stsi_pkg::COUNT_W-1:0]   count;

  modport source (output valid, found, index, status, count, input ready);
  modport sink   (input valid, found, index, status, count, output ready);
endinterface

[hdl/sorted_table_insert_search_unit.sv]
// ----------------------------------------------------------------------------
// sorted_table_insert_search_unit
// Ascending table of signed 32-bit keys with insert, binary and linear search.
// ----------------------------------------------------------------------------
// One item is worked at a time; every item gives exactly one result item. The
// table sits in a memory with one write port and one registered read port,
// and that memory sets the pace: an insert moves up each key greater than
// the new one and then writes the new key, a full-table reject or an unused
// command goes straight to the result, a linear search scans entries in turn
// (at most CAPACITY), and a binary search probes midpoints (at most
// clog2(CAPACITY)+1 probes). A new item is taken as soon as the previous
// result has been placed in the output register, even if that result is
// still waiting to be taken. Table contents are not cleared at reset; only
// the count is, and entries at or above the count never decide a result.
`include "sorted_table_insert_search_unit_defines.svh"

module sorted_table_insert_search_unit #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  stsi_in_if.sink    in_ch,
  stsi_out_if.source out_ch
);
  import stsi_pkg::*;

  stsi_ctl_t ctl;   // sequencer commands
  stsi_sts_t sts;   // datapath flags

  // Sequencer: IDLE accepts, *_CMP states walk the table, RESP issues result
  stsi_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .sts   (sts),
    .ctl   (ctl)
  );

  // Table memory, cursors, key compare and output register
  stsi_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sts    (sts),
    .in_key (in_ch.key),
    .out_ch (out_ch)
  );

  // Short names for the checked terms
  logic       in_take;
  logic       rej_out;
  logic       rej_clean;
  logic [5:0] dp_acts;

  assign in_take   = in_ch.valid && in_ch.ready;
  assign rej_out   = out_ch.valid && out_ch.status;
  assign rej_clean = !out_ch.found && (out_ch.index == '0);
  assign dp_acts   = {ctl.load, ctl.ins_shift, ctl.ins_place,
                      ctl.seq_step, ctl.bin_step, ctl.res_load};

  // One item in flight: right after an accept the port must be closed
  `STSI_ASSERT_NEXT(a_one_in_flight, in_take, !in_ch.ready, "item accepted while busy")
  // A waiting result is never overwritten
  `STSI_ASSERT_NOW(a_no_overwrite, ctl.res_load, sts.slot_free, "result register overwritten")
  // Datapath actions are mutually exclusive
  `STSI_ASSERT_NOW(a_one_action, 1'b1, $onehot0(dp_acts), "overlapping datapath commands")
  // A rejected insert carries no match
  `STSI_ASSERT_NOW(a_reject_clean, rej_out, rej_clean, "rejected insert reports a match")

endmodule

[hdl/stsi_ctrl.sv]
// ----------------------------------------------------------------------------
// stsi_ctrl
// Command sequencer: accepts an item, steps the datapath, issues the result.
// ----------------------------------------------------------------------------
module stsi_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  stsi_in_if.sink             in_ch,
  input  stsi_pkg::stsi_sts_t sts,
  output stsi_pkg::stsi_ctl_t ctl
);
  import stsi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PLACE,
    S_SEQ_CMP,
    S_BIN_CMP,
    S_RESP
  } state_t;

  state_t    state_r, state_nxt;
  res_code_t code_r, code_nxt;

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    code_nxt     = code_r;
    ctl          = '0;
    ctl.rd_mode  = RD_AT;
    ctl.res_code = code_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          ctl.load = 1'b1;
          case (in_ch.cmd)
            CMD_INSERT: begin
              ctl.load_ins = 1'b1;
              ctl.rd_mode  = RD_BELOW;
              if (sts.full) begin
                code_nxt  = RES_FULL;
                state_nxt = S_RESP;
              end else if (sts.empty) begin
                state_nxt = S_INS_PLACE;
              end else begin
                state_nxt = S_INS_CMP;
              end
            end
            CMD_BIN: begin
              ctl.rd_mode = RD_MID;
              if (sts.empty) begin
                code_nxt  = RES_NONE;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_BIN_CMP;
              end
            end
            CMD_SEQ: begin
              ctl.rd_mode = RD_AT;
              if (sts.empty) begin
                code_nxt  = RES_NONE;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_SEQ_CMP;
              end
            end
            default: begin
              code_nxt  = RES_NONE;
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_INS_CMP: begin
        ctl.rd_mode = RD_BELOW;
        if (sts.key_lt) begin
          ctl.ins_shift = 1'b1;
          if (sts.i_one) begin
            state_nxt = S_INS_PLACE;
          end
        end else begin
          state_nxt = S_INS_PLACE;
        end
      end
      S_INS_PLACE: begin
        ctl.ins_place = 1'b1;
        code_nxt      = RES_NONE;
        state_nxt     = S_RESP;
      end
      S_SEQ_CMP: begin
        ctl.rd_mode = RD_AT;
        if (sts.key_eq) begin
          code_nxt  = RES_SEQ_HIT;
          state_nxt = S_RESP;
        end else begin
          ctl.seq_step = 1'b1;
          if (sts.seq_last) begin
            code_nxt  = RES_NONE;
            state_nxt = S_RESP;
          end
        end
      end
      S_BIN_CMP: begin
        ctl.rd_mode = RD_MID;
        if (sts.key_eq) begin
          code_nxt  = RES_BIN_HIT;
          state_nxt = S_RESP;
        end else begin
          ctl.bin_step = 1'b1;
          if (sts.bin_done) begin
            code_nxt  = RES_NONE;
            state_nxt = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (sts.slot_free) begin
          ctl.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= RES_NONE;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

endmodule

[hdl/stsi_datapath.sv]
// ----------------------------------------------------------------------------
// stsi_datapath
// Key table memory, cursors, comparators and the result register.
// ----------------------------------------------------------------------------
module stsi_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  stsi_pkg::stsi_ctl_t ctl,
  output stsi_pkg::stsi_sts_t sts,
  input  stsi_pkg::key_t      in_key,
  stsi_out_if.source          out_ch
);
  import stsi_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  // floor((lo + hi1 - 1) / 2), valid while lo < hi1
  function automatic logic [CW-1:0] mid_of(input logic [CW-1:0] lo,
                                           input logic [CW-1:0] hi1);
    logic [CW:0] s;
    s = {1'b0, lo} + {1'b0, hi1} - {{CW{1'b0}}, 1'b1};
    return s[CW:1];
  endfunction

  key_t          mem [CAPACITY];
  key_t          rdata_r;
  key_t          key_r;
  key_t          wr_data;
  logic [PW-1:0] rd_addr;
  logic [PW-1:0] wr_addr;
  logic          wr_en;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hi1_r, hi1_nxt;
  logic [CW-1:0] mid_cur, mid_nxt, hit_pos;

  logic               out_valid_r;
  logic               found_r, status_r;
  logic [INDEX_W-1:0] index_r;
  logic [COUNT_W-1:0] count_r;

  assign mid_cur = mid_of(lo_r, hi1_r);

  always_comb begin
    i_nxt   = i_r;
    lo_nxt  = lo_r;
    hi1_nxt = hi1_r;
    cnt_nxt = cnt_r;
    wr_en   = 1'b0;
    wr_addr = PW'(i_r);
    wr_data = rdata_r;
    if (ctl.load) begin
      i_nxt   = ctl.load_ins ? cnt_r : '0;
      lo_nxt  = '0;
      hi1_nxt = cnt_r;
    end
    if (ctl.ins_shift) begin
      wr_en = 1'b1;
      i_nxt = i_r - ONE_C;
    end
    if (ctl.ins_place) begin
      wr_en   = 1'b1;
      wr_data = key_r;
      cnt_nxt = cnt_r + ONE_C;
    end
    if (ctl.seq_step) begin
      i_nxt = i_r + ONE_C;
    end
    if (ctl.bin_step) begin
      if (sts.key_lt) begin
        hi1_nxt = mid_cur;
      end else begin
        lo_nxt = mid_cur + ONE_C;
      end
    end
  end

  assign mid_nxt = mid_of(lo_nxt, hi1_nxt);

  // Read address follows the next cursor, so the registered read data lines up with the updated cursors
  always_comb begin
    case (ctl.rd_mode)
      RD_BELOW: rd_addr = PW'(i_nxt - ONE_C);
      RD_AT:    rd_addr = PW'(i_nxt);
      default:  rd_addr = PW'(mid_nxt);
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    case (ctl.res_code)
      RES_SEQ_HIT: hit_pos = i_r;
      RES_BIN_HIT: hit_pos = mid_cur;
      default:     hit_pos = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_r <= in_key;
    end
    i_r   <= i_nxt;
    lo_r  <= lo_nxt;
    hi1_r <= hi1_nxt;
    if (ctl.res_load) begin
      found_r  <= (ctl.res_code == RES_SEQ_HIT) || (ctl.res_code == RES_BIN_HIT);
      index_r  <= INDEX_W'(hit_pos);
      status_r <= (ctl.res_code == RES_FULL);
      count_r  <= COUNT_W'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (ctl.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.full      = (cnt_r == CAP_C);
  assign sts.empty     = (cnt_r == '0);
  assign sts.i_one     = (i_r == ONE_C);
  assign sts.key_lt    = (key_r < rdata_r);
  assign sts.key_eq    = (key_r == rdata_r);
  assign sts.seq_last  = ((i_r + ONE_C) == cnt_r);
  assign sts.bin_done  = sts.key_lt ? (lo_r >= mid_cur) : ((mid_cur + ONE_C) >= hi1_r);
  assign sts.slot_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid  = out_valid_r;
  assign out_ch.found  = found_r;
  assign out_ch.index  = index_r;
  assign out_ch.status = status_r;
  assign out_ch.count  = count_r;

endmodule
